FILE: src/kll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword lexer package
// Shared widths, codes, character constants and the token record.
// ----------------------------------------------------------------------------
package kll_pkg;

   localparam int NUMBER_BITS     = 63;
   localparam int MAX_NAME_LENGTH = 255;
   localparam int NAME_CNT_W      = $clog2(MAX_NAME_LENGTH + 1);
   localparam int LEN_W           = 8;
   localparam int LEN_MAX         = (1 << LEN_W) - 1;
   localparam int WIN_W           = 48;
   localparam int KIND_W          = 5;
   localparam int DETAIL_W        = 2;
   localparam int CHAR_W          = 8;
   localparam int REQ_DATA_W      = 8;
   localparam int RSP_PAY_W       = DETAIL_W + NUMBER_BITS + 1 + LEN_W;
   localparam int RSP_DATA_W      = ((RSP_PAY_W + 7) / 8) * 8;

   localparam logic [NUMBER_BITS-1:0] NUMBER_MAX = {NUMBER_BITS{1'b1}};
   localparam logic [WIN_W-1:0]       WIN_FULL   = {WIN_W{1'b1}};

   // lower-cased keyword text, one character per byte, last char lowest
   localparam logic [WIN_W-1:0] KW_DEF    = WIN_W'("def");
   localparam logic [WIN_W-1:0] KW_IF     = WIN_W'("if");
   localparam logic [WIN_W-1:0] KW_WHL    = WIN_W'("while");
   localparam logic [WIN_W-1:0] KW_FOR    = WIN_W'("for");
   localparam logic [WIN_W-1:0] KW_RET    = WIN_W'("return");
   localparam logic [WIN_W-1:0] KW_VOID   = WIN_W'("void");
   localparam logic [WIN_W-1:0] KW_INT    = WIN_W'("int");
   localparam logic [WIN_W-1:0] KW_CHAR   = WIN_W'("char");
   localparam logic [WIN_W-1:0] KW_TRUE   = WIN_W'("true");
   localparam logic [WIN_W-1:0] KW_FALSE  = WIN_W'("false");

   localparam logic [CHAR_W-1:0] CH_HASH     = "#";
   localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE    = " ";
   localparam logic [CHAR_W-1:0] CH_LPAREN   = "(";
   localparam logic [CHAR_W-1:0] CH_RPAREN   = ")";
   localparam logic [CHAR_W-1:0] CH_LBRACE   = "{";
   localparam logic [CHAR_W-1:0] CH_RBRACE   = "}";
   localparam logic [CHAR_W-1:0] CH_LBRACKET = "[";
   localparam logic [CHAR_W-1:0] CH_RBRACKET = "]";
   localparam logic [CHAR_W-1:0] CH_SEMI     = ";";
   localparam logic [CHAR_W-1:0] CH_COLON    = ":";
   localparam logic [CHAR_W-1:0] CH_COMMA    = ",";
   localparam logic [CHAR_W-1:0] CH_PLUS     = "+";
   localparam logic [CHAR_W-1:0] CH_MINUS    = "-";
   localparam logic [CHAR_W-1:0] CH_STAR     = "*";
   localparam logic [CHAR_W-1:0] CH_SLASH    = "/";
   localparam logic [CHAR_W-1:0] CH_ZERO     = "0";
   localparam logic [CHAR_W-1:0] CH_NINE     = "9";
   localparam logic [CHAR_W-1:0] CH_LOWER_A  = "a";
   localparam logic [CHAR_W-1:0] CH_LOWER_Z  = "z";
   localparam logic [CHAR_W-1:0] CH_UPPER_A  = "A";
   localparam logic [CHAR_W-1:0] CH_UPPER_Z  = "Z";
   localparam logic [CHAR_W-1:0] CASE_BIT    = 8'h20;

   localparam logic [DETAIL_W-1:0] DT_VOID    = 2'd0;
   localparam logic [DETAIL_W-1:0] DT_INT     = 2'd1;
   localparam logic [DETAIL_W-1:0] DT_CHAR    = 2'd2;
   localparam logic [DETAIL_W-1:0] BOOL_FALSE = 2'd0;
   localparam logic [DETAIL_W-1:0] BOOL_TRUE  = 2'd1;
   localparam logic [DETAIL_W-1:0] OP_ADD     = 2'd0;
   localparam logic [DETAIL_W-1:0] OP_SUB     = 2'd1;
   localparam logic [DETAIL_W-1:0] OP_MUL     = 2'd2;
   localparam logic [DETAIL_W-1:0] OP_DIV     = 2'd3;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_NAME    = 3'd1,
      MODE_NUMBER  = 3'd2,
      MODE_COMMENT = 3'd3
   } scan_mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_IDENT    = 5'd0,
      KIND_DEF      = 5'd1,
      KIND_IF       = 5'd2,
      KIND_WHILE    = 5'd3,
      KIND_FOR      = 5'd4,
      KIND_RETURN   = 5'd5,
      KIND_DATATYPE = 5'd6,
      KIND_BOOL     = 5'd7,
      KIND_NUMBER   = 5'd8,
      KIND_LPAREN   = 5'd9,
      KIND_RPAREN   = 5'd10,
      KIND_LBRACE   = 5'd11,
      KIND_RBRACE   = 5'd12,
      KIND_LBRACKET = 5'd13,
      KIND_RBRACKET = 5'd14,
      KIND_SEMI     = 5'd15,
      KIND_COLON    = 5'd16,
      KIND_COMMA    = 5'd17,
      KIND_BINOP    = 5'd18,
      KIND_INVALID  = 5'd19,
      KIND_END      = 5'd20
   } token_kind_type;

   typedef struct packed {
      token_kind_type         kind;
      logic [DETAIL_W-1:0]    detail;
      logic [NUMBER_BITS-1:0] value;
      logic                   overflow;
      logic [LEN_W-1:0]       name_length;
      logic                   last;
   } token_type;

   // up to two tokens produced by one character, oldest in t0
   typedef struct packed {
      logic [1:0] count;
      token_type  t0;
      token_type  t1;
   } token_pair_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

FILE: src/kll_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword lexer scanner
// Holds the scan state and turns one character into zero to two tokens.
// ----------------------------------------------------------------------------
module kll_scan (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  logic [kll_pkg::CHAR_W-1:0]       char_code,
   input  logic                             end_of_input,
   output kll_pkg::token_pair_type          tokens
);
   import kll_pkg::*;

   scan_mode_type          mode_ff, mode_in;
   logic [WIN_W-1:0]       win_ff, win_in;
   logic [NAME_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUMBER_BITS-1:0] acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;

   logic                   letter, digit, alnum;
   logic [CHAR_W-1:0]      lower;
   logic [3:0]             digit_val;
   logic [NAME_CNT_W-1:0]  cnt_add;
   logic [WIN_W-1:0]       win_add;
   logic [NUMBER_BITS+3:0] prod;
   logic                   acc_over;
   logic                   leaving, restart;
   token_type              flush_tok, start_tok, first_tok, second_tok;
   logic                   flush_valid, start_valid, first_v, second_v;

   assign letter    = is_letter(char_code);
   assign digit     = is_digit(char_code);
   assign alnum     = letter || digit;
   assign lower     = letter ? (char_code | CASE_BIT) : char_code;
   assign digit_val = 4'(char_code - CH_ZERO);

   // name extension: saturating count, window goes all ones past six chars
   assign cnt_add = (32'(cnt_ff) < MAX_NAME_LENGTH) ? NAME_CNT_W'(cnt_ff + 1'b1) : cnt_ff;
   assign win_add = ((win_ff == WIN_FULL) || (win_ff[WIN_W-1 -: CHAR_W] != '0))
                    ? WIN_FULL : {win_ff[WIN_W-CHAR_W-1:0], lower};

   // acc * 10 + digit as shifts and two adds; anything above the range overflows
   assign prod = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                 + (NUMBER_BITS+4)'(digit_val);
   assign acc_over = ovf_ff || (prod[NUMBER_BITS+3:NUMBER_BITS] != 4'd0);

   assign leaving = ((mode_ff == MODE_NAME) && !alnum) ||
                    ((mode_ff == MODE_NUMBER) && !digit);
   assign restart = leaving || (mode_ff == MODE_IDLE);

   // next state
   always_comb begin
      mode_in = mode_ff;
      win_in  = win_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      ovf_in  = ovf_ff;
      if (end_of_input) begin
         mode_in = MODE_IDLE;
         win_in  = '0;
         cnt_in  = '0;
         acc_in  = '0;
         ovf_in  = 1'b0;
      end else if (mode_ff == MODE_COMMENT) begin
         if ((char_code == CH_LF) || (char_code == CH_CR)) begin
            mode_in = MODE_IDLE;
         end
      end else if ((mode_ff == MODE_NAME) && alnum) begin
         cnt_in = cnt_add;
         win_in = win_add;
      end else if ((mode_ff == MODE_NUMBER) && digit) begin
         acc_in = acc_over ? NUMBER_MAX : prod[NUMBER_BITS-1:0];
         ovf_in = acc_over;
      end else begin
         // start fresh from this character
         mode_in = MODE_IDLE;
         win_in  = '0;
         cnt_in  = '0;
         acc_in  = '0;
         ovf_in  = 1'b0;
         if (letter) begin
            mode_in = MODE_NAME;
            cnt_in  = NAME_CNT_W'(1);
            win_in  = WIN_W'(lower);
         end else if (digit) begin
            mode_in = MODE_NUMBER;
            acc_in  = NUMBER_BITS'(digit_val);
         end else if (char_code == CH_HASH) begin
            mode_in = MODE_COMMENT;
         end
      end
   end

   // token of the pending name or number
   always_comb begin
      flush_tok   = '0;
      flush_valid = (mode_ff == MODE_NAME) || (mode_ff == MODE_NUMBER);
      if (mode_ff == MODE_NUMBER) begin
         flush_tok.kind     = KIND_NUMBER;
         flush_tok.value    = acc_ff;
         flush_tok.overflow = ovf_ff;
      end else begin
         flush_tok.name_length = (32'(cnt_ff) > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(cnt_ff);
         case (win_ff)
            KW_DEF:    flush_tok.kind = KIND_DEF;
            KW_IF:     flush_tok.kind = KIND_IF;
            KW_WHL:    flush_tok.kind = KIND_WHILE;
            KW_FOR:    flush_tok.kind = KIND_FOR;
            KW_RET:    flush_tok.kind = KIND_RETURN;
            KW_VOID: begin
               flush_tok.kind   = KIND_DATATYPE;
               flush_tok.detail = DT_VOID;
            end
            KW_INT: begin
               flush_tok.kind   = KIND_DATATYPE;
               flush_tok.detail = DT_INT;
            end
            KW_CHAR: begin
               flush_tok.kind   = KIND_DATATYPE;
               flush_tok.detail = DT_CHAR;
            end
            KW_TRUE: begin
               flush_tok.kind   = KIND_BOOL;
               flush_tok.detail = BOOL_TRUE;
            end
            KW_FALSE: begin
               flush_tok.kind   = KIND_BOOL;
               flush_tok.detail = BOOL_FALSE;
            end
            default:   flush_tok.kind = KIND_IDENT;
         endcase
      end
   end

   // single-character token, if this character makes one
   always_comb begin
      start_tok   = '0;
      start_valid = !(is_space(char_code) || alnum || (char_code == CH_HASH));
      case (char_code)
         CH_LPAREN:   start_tok.kind = KIND_LPAREN;
         CH_RPAREN:   start_tok.kind = KIND_RPAREN;
         CH_LBRACE:   start_tok.kind = KIND_LBRACE;
         CH_RBRACE:   start_tok.kind = KIND_RBRACE;
         CH_LBRACKET: start_tok.kind = KIND_LBRACKET;
         CH_RBRACKET: start_tok.kind = KIND_RBRACKET;
         CH_SEMI:     start_tok.kind = KIND_SEMI;
         CH_COLON:    start_tok.kind = KIND_COLON;
         CH_COMMA:    start_tok.kind = KIND_COMMA;
         CH_PLUS: begin
            start_tok.kind   = KIND_BINOP;
            start_tok.detail = OP_ADD;
         end
         CH_MINUS: begin
            start_tok.kind   = KIND_BINOP;
            start_tok.detail = OP_SUB;
         end
         CH_STAR: begin
            start_tok.kind   = KIND_BINOP;
            start_tok.detail = OP_MUL;
         end
         CH_SLASH: begin
            start_tok.kind   = KIND_BINOP;
            start_tok.detail = OP_DIV;
         end
         default:     start_tok.kind = KIND_INVALID;
      endcase
   end

   // order the tokens and mark the final one
   always_comb begin
      first_tok       = flush_tok;
      first_v         = flush_valid && (end_of_input || leaving);
      second_tok      = start_tok;
      second_v        = !end_of_input && restart && start_valid;
      if (end_of_input) begin
         second_tok      = '0;
         second_tok.kind = KIND_END;
         second_v        = 1'b1;
      end
      tokens = '0;
      if (first_v) begin
         tokens.t0    = first_tok;
         tokens.t1    = second_tok;
         tokens.count = second_v ? 2'd2 : 2'd1;
         if (second_v) begin
            tokens.t1.last = 1'b1;
         end else begin
            tokens.t0.last = 1'b1;
         end
      end else begin
         tokens.t0      = second_tok;
         tokens.t0.last = 1'b1;
         tokens.count   = second_v ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         win_ff  <= '0;
         cnt_ff  <= '0;
         acc_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (fire) begin
         mode_ff <= mode_in;
         win_ff  <= win_in;
         cnt_ff  <= cnt_in;
         acc_ff  <= acc_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule

FILE: src/kll_rspq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword lexer result queue
// Two-entry token buffer; loads a token pair when empty, drains one per cycle while pop is high.
// ----------------------------------------------------------------------------
module kll_rspq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  kll_pkg::token_pair_type pair,
   input  logic                    pop,
   output kll_pkg::token_type      head,
   output logic                    head_valid,
   output logic                    room
);
   import kll_pkg::*;

   token_type  e0_ff, e0_in, e1_ff, e1_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head       = e0_ff;
   assign head_valid = (cnt_ff != 2'd0);
   // empty by the end of this cycle
   assign room       = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);

   always_comb begin
      e0_in  = e0_ff;
      e1_in  = e1_ff;
      cnt_in = cnt_ff;
      if (push) begin
         e0_in  = pair.t0;
         e1_in  = pair.t1;
         cnt_in = pair.count;
      end else if (pop) begin
         e0_in  = e1_ff;
         cnt_in = 2'(cnt_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

endmodule

FILE: src/keyword_lexer_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword lexer tokenizer unit
// Streams character bytes in and tokens out: names, keywords, numbers,
// punctuation, operators, invalid bytes and an end token.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                       | tuser      | tlast
//  --------+-----------+-----------------------------+------------+-------------
//  req_    | in        | char_code                   | -          | end_of_input
//  rsp_    | out       | detail, number_value,       | token_kind | last token
//          |           | number_overflow, name_length|            | of the byte
//
//  One byte is taken per cycle while each byte yields at most one token and
//  rsp_tready stays high; a byte that yields two tokens holds the next byte
//  until the two-entry result queue, draining one token per cycle, pops its
//  last token. A byte crosses the input register and the result queue before
//  its first token shows. Reset (synchronous, active high) returns the
//  scanner to idle between tokens and empties the input register and the
//  result queue. While a token waits on rsp_, the input register holds at
//  most one byte and req_tready drops until the queue can drain.
// ----------------------------------------------------------------------------
module keyword_lexer_tokenizer_unit (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [7:0] char_code
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [kll_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tlast,
   // rsp_tdata: [1:0] detail, [64:2] number_value, [65] number_overflow,
   //            [73:66] name_length, [79:74] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kll_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: [4:0] token_kind
   output logic [kll_pkg::KIND_W-1:0]          rsp_tuser,
   output logic                                rsp_tlast
);
   import kll_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_eoi_ff;

   logic              fire;
   logic              pop;
   logic              room;
   token_pair_type    pair;
   token_type         head;

   // advance a byte into the scanner once the result queue will be empty
   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the byte until the scanner takes it
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata[CHAR_W-1:0];
         in_eoi_ff  <= req_tlast;
      end
   end

   kll_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .char_code    (in_char_ff),
      .end_of_input (in_eoi_ff),
      .tokens       (pair)
   );

   kll_rspq u_rspq (
      .clock      (clock),
      .reset      (reset),
      .push       (fire),
      .pair       (pair),
      .pop        (pop),
      .head       (head),
      .head_valid (rsp_tvalid),
      .room       (room)
   );

   // pack the head token onto the result channel
   assign rsp_tdata = {(RSP_DATA_W - RSP_PAY_W)'(0), head.name_length, head.overflow,
                       head.value, head.detail};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   // a byte enters the scanner only when no token waits or the waiting one is taken
   assert property (@(posedge clock) disable iff (reset)
      fire |-> (!rsp_tvalid || rsp_tready))
      else $error("scanner fired while a token still waited");

   // end of input always yields at least the end token
   assert property (@(posedge clock) disable iff (reset)
      (fire && in_eoi_ff) |=> rsp_tvalid)
      else $error("end of input produced no token");

   // the end token is always the final token of its byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_END)) |-> rsp_tlast)
      else $error("end token not marked last");

   // only number tokens carry a value or an overflow flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != KIND_NUMBER)) |->
         ((head.value == '0) && !head.overflow))
      else $error("non-number token carries a value");

endmodule

FILE: tb/sv/keyword_lexer_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword lexer tokenizer unit testbench
// Streams character bytes and end marks into the lexer. A scoreboard predicts
// the tokens of every byte transfer and compares each token transfer, field
// by field and in order. A short directed sequence comes first. Random token
// text, comments, noise bytes and end marks follow under three patterns of
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module keyword_lexer_tokenizer_unit_tb;

   import kll_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   // -------------------------------------------------------------------------
   // Scoreboard: its own copy of the scanner state, plus the tokens predicted
   // for byte transfers that have not yet come out of the block
   // -------------------------------------------------------------------------
   class token_scoreboard;
      token_type              predicted_tokens[$];
      scan_mode_type          mode;
      logic [WIN_W-1:0]       window;
      int unsigned            name_chars;
      logic [NUMBER_BITS-1:0] accum;
      logic                   accum_sat;
      int unsigned            errors;
      int unsigned            bytes_seen;
      int unsigned            end_marks;
      int unsigned            tokens_checked;
      int unsigned            saturated_numbers;

      function new();
         errors            = 0;
         bytes_seen        = 0;
         end_marks         = 0;
         tokens_checked    = 0;
         saturated_numbers = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         mode       = MODE_IDLE;
         window     = '0;
         name_chars = 0;
         accum      = '0;
         accum_sat  = 1'b0;
      endfunction

      function bit blank_char(logic [CHAR_W-1:0] c);
         return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
      endfunction

      function bit alpha_char(logic [CHAR_W-1:0] c);
         return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
      endfunction

      function bit digit_char(logic [CHAR_W-1:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      function void push_token(token_kind_type kind, logic [DETAIL_W-1:0] detail,
                               logic [NUMBER_BITS-1:0] value, logic ovf,
                               logic [LEN_W-1:0] len);
         token_type t;
         t.kind        = kind;
         t.detail      = detail;
         t.value       = value;
         t.overflow    = ovf;
         t.name_length = len;
         t.last        = 1'b0;
         predicted_tokens.push_back(t);
      endfunction

      // Shift in the lower-cased character; once more than six characters
      // have gone by, pin the window to all ones so no keyword can match.
      function void grow_name(logic [CHAR_W-1:0] c);
         if (name_chars < MAX_NAME_LENGTH) name_chars++;
         if (window == WIN_FULL || window[WIN_W-1:WIN_W-8] != 0) begin
            window = WIN_FULL;
         end else begin
            window = {window[WIN_W-9:0], alpha_char(c) ? (c | CASE_BIT) : c};
         end
      endfunction

      // Multiply-add by ten, saturating at the all-ones value for good
      function void grow_number(logic [CHAR_W-1:0] c);
         logic [63:0] d;
         logic [63:0] top;
         d   = 64'(c - CH_ZERO);
         top = 64'(NUMBER_MAX);
         if (accum_sat || 64'(accum) > (top - d) / 10) begin
            accum     = NUMBER_MAX;
            accum_sat = 1'b1;
         end else begin
            accum = NUMBER_BITS'(64'(accum) * 10 + d);
         end
      endfunction

      // Emit the pending name or number, if any, and go back to idle
      function void close_lexeme();
         token_kind_type      kind;
         logic [DETAIL_W-1:0] detail;
         if (mode == MODE_NAME) begin
            detail = '0;
            case (window)
               KW_DEF:    kind = KIND_DEF;
               KW_IF:     kind = KIND_IF;
               KW_WHL:    kind = KIND_WHILE;
               KW_FOR:    kind = KIND_FOR;
               KW_RET:    kind = KIND_RETURN;
               KW_VOID:   begin kind = KIND_DATATYPE; detail = DT_VOID;    end
               KW_INT:    begin kind = KIND_DATATYPE; detail = DT_INT;     end
               KW_CHAR:   begin kind = KIND_DATATYPE; detail = DT_CHAR;    end
               KW_TRUE:   begin kind = KIND_BOOL;     detail = BOOL_TRUE;  end
               KW_FALSE:  begin kind = KIND_BOOL;     detail = BOOL_FALSE; end
               default:   kind = KIND_IDENT;
            endcase
            push_token(kind, detail, '0, 1'b0,
                       name_chars > LEN_MAX ? LEN_W'(LEN_MAX) : LEN_W'(name_chars));
         end else if (mode == MODE_NUMBER) begin
            if (accum_sat) saturated_numbers++;
            push_token(KIND_NUMBER, '0, accum, accum_sat, '0);
         end
         clear_scan();
      endfunction

      // Treat a character as the start of whatever follows
      function void open_lexeme(logic [CHAR_W-1:0] c);
         if (blank_char(c)) return;
         if (alpha_char(c)) begin
            mode = MODE_NAME;
            grow_name(c);
         end else if (digit_char(c)) begin
            mode = MODE_NUMBER;
            grow_number(c);
         end else if (c == CH_HASH) begin
            mode = MODE_COMMENT;
         end else begin
            case (c)
               CH_LPAREN:   push_token(KIND_LPAREN,   '0, '0, 1'b0, '0);
               CH_RPAREN:   push_token(KIND_RPAREN,   '0, '0, 1'b0, '0);
               CH_LBRACE:   push_token(KIND_LBRACE,   '0, '0, 1'b0, '0);
               CH_RBRACE:   push_token(KIND_RBRACE,   '0, '0, 1'b0, '0);
               CH_LBRACKET: push_token(KIND_LBRACKET, '0, '0, 1'b0, '0);
               CH_RBRACKET: push_token(KIND_RBRACKET, '0, '0, 1'b0, '0);
               CH_SEMI:     push_token(KIND_SEMI,     '0, '0, 1'b0, '0);
               CH_COLON:    push_token(KIND_COLON,    '0, '0, 1'b0, '0);
               CH_COMMA:    push_token(KIND_COMMA,    '0, '0, 1'b0, '0);
               CH_PLUS:     push_token(KIND_BINOP, OP_ADD, '0, 1'b0, '0);
               CH_MINUS:    push_token(KIND_BINOP, OP_SUB, '0, 1'b0, '0);
               CH_STAR:     push_token(KIND_BINOP, OP_MUL, '0, 1'b0, '0);
               CH_SLASH:    push_token(KIND_BINOP, OP_DIV, '0, 1'b0, '0);
               default:     push_token(KIND_INVALID, '0, '0, 1'b0, '0);
            endcase
         end
      endfunction

      // Note one accepted byte transfer and predict the tokens it causes
      function void note_char(logic [CHAR_W-1:0] c, logic eoi);
         int unsigned queued;
         queued = predicted_tokens.size();
         bytes_seen++;
         if (eoi) begin
            end_marks++;
            close_lexeme();
            push_token(KIND_END, '0, '0, 1'b0, '0);
         end else begin
            case (mode)
               MODE_COMMENT: begin
                  if (c == CH_LF || c == CH_CR) mode = MODE_IDLE;
               end
               MODE_NAME: begin
                  if (alpha_char(c) || digit_char(c)) begin
                     grow_name(c);
                  end else begin
                     close_lexeme();
                     open_lexeme(c);
                  end
               end
               MODE_NUMBER: begin
                  if (digit_char(c)) begin
                     grow_number(c);
                  end else begin
                     close_lexeme();
                     open_lexeme(c);
                  end
               end
               default: begin
                  mode = MODE_IDLE;
                  open_lexeme(c);
               end
            endcase
         end
         // flag the final token of this byte
         if (predicted_tokens.size() > queued)
            predicted_tokens[predicted_tokens.size() - 1].last = 1'b1;
      endfunction

      function bit field_ok(string field, logic [63:0] exp, logic [63:0] act);
         if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp, act);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      // Compare one token transfer with the oldest prediction
      function void check_token(logic [KIND_W-1:0] kind, logic [DETAIL_W-1:0] detail,
                                logic [NUMBER_BITS-1:0] value, logic ovf,
                                logic [LEN_W-1:0] len, logic last);
         token_type exp;
         bit        ok;
         tokens_checked++;
         if (predicted_tokens.size() == 0) begin
            $display("%0t: token with no prediction, expected none, actual kind %0d",
                     $time, kind);
            errors++;
            return;
         end
         exp = predicted_tokens.pop_front();
         ok  = field_ok("token_kind", 64'(exp.kind), 64'(kind));
         ok  = field_ok("detail", 64'(exp.detail), 64'(detail)) && ok;
         ok  = field_ok("number_value", 64'(exp.value), 64'(value)) && ok;
         ok  = field_ok("number_overflow", 64'(exp.overflow), 64'(ovf)) && ok;
         ok  = field_ok("name_length", 64'(exp.name_length), 64'(len)) && ok;
         ok  = field_ok("last", 64'(exp.last), 64'(last)) && ok;
         if (!ok) errors++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block
   // -------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   keyword_lexer_tokenizer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] char_code
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [1:0] detail, [64:2] value, [65] overflow, [73:66] length
      .rsp_tuser  (rsp_tuser),   // [4:0] token_kind
      .rsp_tlast  (rsp_tlast)
   );

   token_scoreboard board;
   int unsigned     send_gap_pct  = 0;
   int unsigned     rsp_stall_pct = 0;
   int unsigned     items_sent    = 0;
   int unsigned     cycle_count   = 0;

   // Receiver: stall at random, at the rate of the current phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Monitors: both sample the values from before the edge, so no race
   // with the block's own registers
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_char(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_token(rsp_tuser, rsp_tdata[1:0], rsp_tdata[64:2], rsp_tdata[65],
                           rsp_tdata[73:66], rsp_tlast);
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------

   // Offer one byte (or end mark) and hold it until the transfer completes.
   // A random gap may come first; valid then stays high through back-to-back
   // transfers, since the next call drives it only once per edge.
   task automatic send_item(logic [CHAR_W-1:0] c, logic eoi);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eoi;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   function automatic logic [CHAR_W-1:0] any_letter();
      return $urandom_range(1) ? CHAR_W'(CH_LOWER_A + $urandom_range(25))
                               : CHAR_W'(CH_UPPER_A + $urandom_range(25));
   endfunction

   function automatic logic [CHAR_W-1:0] any_alnum();
      return $urandom_range(4) == 0 ? CHAR_W'(CH_ZERO + $urandom_range(9)) : any_letter();
   endfunction

   // Mostly well-formed token text with random content; the rest is blanks,
   // comments, noise bytes and end marks in any position.
   task automatic send_random_lexeme();
      string       kw_texts[10] = '{"def", "if", "while", "for", "return",
                                    "void", "int", "char", "true", "false"};
      string       marks        = "(){}[];:,+-*/";
      int unsigned pick;
      int unsigned len;
      string       s;
      logic [7:0]  c;
      pick = $urandom_range(99);
      if (pick < 18) begin
         // keyword in random case
         s = kw_texts[$urandom_range(9)];
         for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            send_item($urandom_range(1) ? (c & ~CASE_BIT) : c, 1'b0);
         end
      end else if (pick < 33) begin
         // identifier; some longer than the keyword window
         len = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
         send_item(any_letter(), 1'b0);
         for (int i = 1; i < len; i++) send_item(any_alnum(), 1'b0);
      end else if (pick < 48) begin
         // number; now and then at or beyond the saturation point
         case ($urandom_range(19))
            0:       send_text("9223372036854775807");
            1:       send_text("9223372036854775808");
            2: begin
               send_item(CHAR_W'(CH_ZERO + $urandom_range(1, 9)), 1'b0);
               len = $urandom_range(18, 21);
               for (int i = 0; i < len; i++)
                  send_item(CHAR_W'(CH_ZERO + $urandom_range(9)), 1'b0);
            end
            default: begin
               len = $urandom_range(1, 6);
               for (int i = 0; i < len; i++)
                  send_item(CHAR_W'(CH_ZERO + $urandom_range(9)), 1'b0);
            end
         endcase
      end else if (pick < 63) begin
         send_item(marks[$urandom_range(marks.len() - 1)], 1'b0);
      end else if (pick < 75) begin
         send_item($urandom_range(5) == 0 ? CH_SPACE : CHAR_W'(CH_TAB + $urandom_range(4)),
                   1'b0);
      end else if (pick < 82) begin
         // comment with random body, closed by LF, CR or the end of input
         send_item(CH_HASH, 1'b0);
         len = $urandom_range(6);
         for (int i = 0; i < len; i++) begin
            c = CHAR_W'($urandom_range(255));
            send_item((c == CH_LF || c == CH_CR) ? CH_LOWER_A : c, 1'b0);
         end
         case ($urandom_range(4))
            0:       send_item(CHAR_W'($urandom_range(255)), 1'b1);
            1:       send_item(CH_CR, 1'b0);
            default: send_item(CH_LF, 1'b0);
         endcase
      end else if (pick < 96) begin
         send_item(CHAR_W'($urandom_range(255)), 1'b0);
      end else begin
         send_item(CHAR_W'($urandom_range(255)), 1'b1);
      end
   endtask

   // Watchdog: a stuck handshake ends the run here
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d tokens still predicted",
               cycle_count, board.predicted_tokens.size());
      $display("*** FAILED ***");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      board         = new();
      send_gap_pct  = 27;
      rsp_stall_pct = 51;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: mixed-case keyword ended by punctuation, byte zero and the
      // top byte, a number ended by a bracket, a name with a digit, ended by
      // an operator, operators back to back, then a comment cut off by the
      // end of input and a name flushed by the end of input.
      send_text("WhIlE{");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h80, 1'b0);
      send_text("70]x9+-*/");
      send_text("#z");
      send_item(8'hFF, 1'b1);
      send_text("Ab");
      send_item(8'h00, 1'b1);

      // Phase one: sender gaps light, receiver stalls heavy
      while (items_sent < 160) send_random_lexeme();

      // Phase two: the other way round
      send_gap_pct  = 51;
      rsp_stall_pct = 27;
      while (items_sent < 300) send_random_lexeme();

      // Phase three: full rate both ways; one name long enough to saturate
      // the length count
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      send_item(CH_UPPER_A, 1'b0);
      for (int i = 1; i < 260; i++) send_item(any_alnum(), 1'b0);
      send_item(CH_SPACE, 1'b0);
      while (items_sent < 600) send_random_lexeme();
      send_item(CH_SPACE, 1'b1);
      req_tvalid <= 1'b0;

      // Drain, then let the pipeline settle to catch any stray token
      while (board.predicted_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.predicted_tokens.size() != 0) begin
         $display("%0d predicted tokens never arrived", board.predicted_tokens.size());
         board.errors += board.predicted_tokens.size();
      end
      $display("Covered %0d byte transfers (%0d end marks) and %0d token transfers,",
               board.bytes_seen, board.end_marks, board.tokens_checked);
      $display("with %0d saturated numbers, over three gap and stall patterns; %0d errors",
               board.saturated_numbers, board.errors);
      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
